// ===== design/multi_stack_shared_pool_assert.svh =====
// ----------------------------------------------------------------------------
// multi_stack_shared_pool assertion macros
// Property shorthands for the shared-pool stack checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_STACK_SHARED_POOL_ASSERT_SVH
`define MULTI_STACK_SHARED_POOL_ASSERT_SVH

// same-cycle implication
`define MSSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mssp_pkg.sv =====
// ----------------------------------------------------------------------------
// mssp_pkg
// Types, codes and defaults shared by the shared-pool stack block.
// ----------------------------------------------------------------------------
`default_nettype none

package mssp_pkg;

    // fixed field widths
    localparam int FUNC_W = 2;
    localparam int ID_W   = 3;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 4;

    // parameter defaults
    localparam int NUM_STACKS_DEF = 8;
    localparam int POOL_DEPTH_DEF = 32;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [CFG_W-1:0] STACKS_RESET = 4'd8;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LIST = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_BADID = 2'd3;

    // single-result actions chosen by the controller
    localparam int ACT_W = 3;
    localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_BADID = 3'd3;
    localparam logic [ACT_W-1:0] ACT_EMPTY = 3'd4;
    localparam logic [ACT_W-1:0] ACT_FULL  = 3'd5;

    // register map
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] ADDR_STACKS_IN_USE = 3'd0;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [ID_W-1:0]          stack_id;
        logic signed [WORD_W-1:0] item;
    } t_in_word;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic [STAT_W-1:0]        status;
        logic                     last;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic             capture;
        logic             rd_req;
        logic             exec;
        logic             list_step;
        logic [ACT_W-1:0] act;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_push;
        logic is_pop;
        logic is_list;
        logic bad_id;
        logic empty;
        logic full;
        logic list_end;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== design/multi_stack_shared_pool.sv =====
// ----------------------------------------------------------------------------
// multi_stack_shared_pool
// Several LIFO stacks drawing linked nodes from one shared pool.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low. Each result
// word sits on o_res for exactly one cycle with o_res_valid high; there is
// no backpressure, so the receiver must take every word as it comes.
// Order, counted from the accepting edge: push, pop and every error pass
// through DECODE and EXEC and give their single word in EXEC; busy drops
// once EXEC is over, so the next item is taken only after that. A list of N
// nodes passes DECODE, then streams N words on consecutive cycles in LIST;
// an unused operation code returns from DECODE to idle and gives no word.
// The order is set by the single-port node memory, whose read data is
// registered: the node is fetched in DECODE, then used and written back.
// Node memory needs no clearing after reset; the block is ready at once.
// Register 0 (byte 0): stacks_in_use, 4 bits, reset 8. Write it only while
// busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_stack_shared_pool #(
    parameter int NUM_STACKS = mssp_pkg::NUM_STACKS_DEF,
    parameter int POOL_DEPTH = mssp_pkg::POOL_DEPTH_DEF,
    parameter int DATA_WIDTH = mssp_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // command channel
    input  wire logic                              start,
    output logic                                   busy,
    input  wire mssp_pkg::t_in_word                i_op,
    // result channel
    output logic                                   o_res_valid,
    output mssp_pkg::t_out_word                    o_res,
    // register port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mssp_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    logic [mssp_pkg::CFG_W-1:0] r_stacks_in_use;
    logic                       cfg_hit;
    mssp_pkg::t_dp_cmd          dp_cmd;
    mssp_pkg::t_dp_stat         dp_stat;

    // --- register port ----------------------------------------------------
    // pready is tied high. Only the one register decodes; other addresses
    // read as zero and drop writes.
    assign pready  = 1'b1;
    assign cfg_hit = (paddr == mssp_pkg::ADDR_STACKS_IN_USE);
    assign prdata  = cfg_hit ? 32'(r_stacks_in_use) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stacks_in_use <= mssp_pkg::STACKS_RESET;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_stacks_in_use <= pwdata[mssp_pkg::CFG_W-1:0];
        end
    end

    // --- sequencer --------------------------------------------------------
    // IDLE -> DECODE (classify, fetch node) -> EXEC (one word, write back)
    //                                       -> LIST (one word per node)
    mssp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // --- datapath ---------------------------------------------------------
    // Stack heads with valid bits, free list head, fresh-node counter and
    // the node memory. Popped nodes are pushed onto the free list, and
    // pushes reuse them before touching untouched pool entries.
    mssp_dp #(
        .NUM_STACKS (NUM_STACKS),
        .POOL_DEPTH (POOL_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (i_op),
        .i_stacks_in_use (r_stacks_in_use),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .o_res           (o_res),
        .o_res_valid     (o_res_valid)
    );

endmodule

`default_nettype wire

// ===== design/mssp_dp.sv =====
// ----------------------------------------------------------------------------
// mssp_dp
// Datapath: stack tops, free list, node memory and result formatting.
// ----------------------------------------------------------------------------
`default_nettype none

module mssp_dp #(
    parameter int NUM_STACKS = mssp_pkg::NUM_STACKS_DEF,
    parameter int POOL_DEPTH = mssp_pkg::POOL_DEPTH_DEF,
    parameter int DATA_WIDTH = mssp_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire mssp_pkg::t_in_word           i_op,
    input  wire logic [mssp_pkg::CFG_W-1:0]   i_stacks_in_use,
    input  wire mssp_pkg::t_dp_cmd            i_cmd,
    output mssp_pkg::t_dp_stat                o_stat,
    output mssp_pkg::t_out_word               o_res,
    output logic                              o_res_valid
);

    localparam int PW  = $clog2(POOL_DEPTH);
    localparam int FW  = $clog2(POOL_DEPTH + 1);
    localparam int SW  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int IXW = (SW > mssp_pkg::ID_W) ? SW : mssp_pkg::ID_W;
    localparam int NW  = 1 + PW + DATA_WIDTH;

    // latched item
    logic [mssp_pkg::FUNC_W-1:0] r_func;
    logic [mssp_pkg::ID_W-1:0]   r_sid;
    logic [DATA_WIDTH-1:0]       r_item;

    // stack heads and free list
    logic [PW-1:0] r_top [NUM_STACKS];
    logic          r_top_vld [NUM_STACKS];
    logic [PW-1:0] r_free_head;
    logic          r_free_vld;
    logic [FW-1:0] r_fresh;
    logic [PW-1:0] r_k;

    // node memory: {link valid, link, value}
    logic [NW-1:0] r_mem [POOL_DEPTH];
    logic [NW-1:0] r_rd;

    logic [IXW-1:0]        sid_ext;
    logic [SW-1:0]         sid_ix;
    logic                  id_bad;
    logic [PW-1:0]         cur_top;
    logic                  cur_vld;
    logic [DATA_WIDTH-1:0] rd_value;
    logic [PW-1:0]         rd_link;
    logic                  rd_lv;
    logic [PW-1:0]         new_node;
    logic                  list_end;
    logic                  do_push;
    logic                  do_pop;
    logic                  rd_en;
    logic [PW-1:0]         rd_addr;
    logic                  wr_en;
    logic [PW-1:0]         wr_addr;
    logic [NW-1:0]         wr_data;

    assign sid_ext = IXW'(r_sid);
    assign sid_ix  = sid_ext[SW-1:0];
    assign id_bad  = (32'(r_sid) >= 32'(NUM_STACKS)) ||
                     ({1'b0, r_sid} >= i_stacks_in_use);
    assign cur_top = id_bad ? '0   : r_top[sid_ix];
    assign cur_vld = id_bad ? 1'b0 : r_top_vld[sid_ix];

    assign rd_value = r_rd[DATA_WIDTH-1:0];
    assign rd_link  = r_rd[DATA_WIDTH+PW-1:DATA_WIDTH];
    assign rd_lv    = r_rd[NW-1];

    // recycled node first, else next never-used node
    assign new_node = r_free_vld ? r_free_head : r_fresh[PW-1:0];
    assign list_end = !rd_lv || (r_k == PW'(POOL_DEPTH - 1));

    assign do_push = i_cmd.exec && (i_cmd.act == mssp_pkg::ACT_PUSH);
    assign do_pop  = i_cmd.exec && (i_cmd.act == mssp_pkg::ACT_POP);

    always_comb begin
        o_stat.is_push  = (r_func == mssp_pkg::FUNC_PUSH);
        o_stat.is_pop   = (r_func == mssp_pkg::FUNC_POP);
        o_stat.is_list  = (r_func == mssp_pkg::FUNC_LIST);
        o_stat.bad_id   = id_bad;
        o_stat.empty    = !cur_vld;
        o_stat.full     = !r_free_vld && (r_fresh == FW'(POOL_DEPTH));
        o_stat.list_end = list_end;
    end

    // one read port: free head for push, top for pop/list, then link chain
    always_comb begin
        rd_en = i_cmd.rd_req || i_cmd.list_step;
        if (i_cmd.list_step) begin
            rd_addr = rd_link;
        end else if (r_func == mssp_pkg::FUNC_PUSH) begin
            rd_addr = r_free_head;
        end else begin
            rd_addr = cur_top;
        end
    end

    always_comb begin
        wr_en   = do_push || do_pop;
        wr_addr = cur_top;
        wr_data = {r_free_vld, r_free_head, rd_value};
        if (do_push) begin
            wr_addr = new_node;
            wr_data = {cur_vld, cur_top, r_item};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_op.func;
            r_sid  <= i_op.stack_id;
            r_item <= DATA_WIDTH'($unsigned(i_op.item));
        end
        if (do_push) begin
            r_top[sid_ix] <= new_node;
            if (r_free_vld) begin
                r_free_head <= rd_link;
            end
        end
        if (do_pop) begin
            r_top[sid_ix] <= rd_link;
            r_free_head   <= cur_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                r_top_vld[i] <= 1'b0;
            end
            r_free_vld <= 1'b0;
            r_fresh    <= '0;
            r_k        <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_k <= '0;
            end else if (i_cmd.list_step) begin
                r_k <= r_k + 1'b1;
            end
            if (do_push) begin
                r_top_vld[sid_ix] <= 1'b1;
                if (r_free_vld) begin
                    r_free_vld <= rd_lv;
                end else begin
                    r_fresh <= r_fresh + 1'b1;
                end
            end
            if (do_pop) begin
                r_top_vld[sid_ix] <= rd_lv;
                r_free_vld        <= 1'b1;
            end
        end
    end

    always_comb begin
        o_res_valid  = i_cmd.exec || i_cmd.list_step;
        o_res.value  = '0;
        o_res.status = mssp_pkg::STATUS_OK;
        o_res.last   = 1'b1;
        if (i_cmd.list_step) begin
            o_res.value = $signed(mssp_pkg::WORD_W'(rd_value));
            o_res.last  = list_end;
        end else begin
            case (i_cmd.act)
                mssp_pkg::ACT_POP:   o_res.value  = $signed(mssp_pkg::WORD_W'(rd_value));
                mssp_pkg::ACT_BADID: o_res.status = mssp_pkg::STATUS_BADID;
                mssp_pkg::ACT_EMPTY: o_res.status = mssp_pkg::STATUS_EMPTY;
                mssp_pkg::ACT_FULL:  o_res.status = mssp_pkg::STATUS_FULL;
                default:             o_res.status = mssp_pkg::STATUS_OK;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/mssp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mssp_ctrl
// Sequencer: decode, single-word execute and list walk.
// ----------------------------------------------------------------------------
`default_nettype none

module mssp_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire mssp_pkg::t_dp_stat   i_stat,
    output mssp_pkg::t_dp_cmd         o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_EXEC   = 2'd2;
    localparam logic [1:0] ST_LIST   = 2'd3;

    logic [1:0]                 r_state;
    logic [1:0]                 n_state;
    logic [mssp_pkg::ACT_W-1:0] r_act;
    logic [mssp_pkg::ACT_W-1:0] n_act;

    assign o_busy = (r_state != ST_IDLE);

    always_comb begin
        n_state         = r_state;
        n_act           = r_act;
        o_cmd.capture   = 1'b0;
        o_cmd.rd_req    = 1'b0;
        o_cmd.exec      = 1'b0;
        o_cmd.list_step = 1'b0;
        o_cmd.act       = mssp_pkg::ACT_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                o_cmd.rd_req = 1'b1;
                n_state      = ST_EXEC;
                if (!(i_stat.is_push || i_stat.is_pop || i_stat.is_list)) begin
                    n_state = ST_IDLE;          // unused code: no word
                end else if (i_stat.bad_id) begin
                    n_act = mssp_pkg::ACT_BADID;
                end else if (i_stat.is_push) begin
                    n_act = i_stat.full ? mssp_pkg::ACT_FULL : mssp_pkg::ACT_PUSH;
                end else if (i_stat.empty) begin
                    n_act = mssp_pkg::ACT_EMPTY;
                end else if (i_stat.is_pop) begin
                    n_act = mssp_pkg::ACT_POP;
                end else begin
                    n_state = ST_LIST;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                o_cmd.act  = r_act;
                n_state    = ST_IDLE;
            end
            ST_LIST: begin
                o_cmd.list_step = 1'b1;
                if (i_stat.list_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_act   <= mssp_pkg::ACT_NONE;
        end else begin
            r_state <= n_state;
            r_act   <= n_act;
        end
    end

endmodule

`default_nettype wire

// ===== design/mssp_checker.sv =====
// ----------------------------------------------------------------------------
// mssp_checker
// Port-level checks on command and result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_stack_shared_pool_assert.svh"

module mssp_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_start,
    input wire logic                 i_busy,
    input wire logic                 i_res_valid,
    input wire mssp_pkg::t_out_word  i_res
);

    // words only come out while an item is in flight
    `MSSP_ASSERT_IMP(a_res_in_flight, i_clk, i_rst_n, i_res_valid, i_busy, "word while idle")

    // an accepted item holds busy on the next cycle
    `MSSP_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_start && !i_busy, i_busy, "no busy after accept")

    // a list run has no gaps until its last word
    `MSSP_ASSERT_NXT(a_list_gapless, i_clk, i_rst_n, i_res_valid && !i_res.last, i_res_valid, "gap in list")

    // error words are single, zero-valued words
    `MSSP_ASSERT_IMP(a_err_word, i_clk, i_rst_n, i_res_valid && (i_res.status != mssp_pkg::STATUS_OK), i_res.last && (i_res.value == '0), "bad error word")

endmodule

bind multi_stack_shared_pool mssp_checker u_mssp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (start),
    .i_busy      (busy),
    .i_res_valid (o_res_valid),
    .i_res       (o_res)
);

`default_nettype wire
